/* design/tce_pkg.sv */
// ----------------------------------------------------------------------------
// tce_pkg
// Shared types and constants for the transitive closure engine: row widths,
// register map, controller state encoding and the command/status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int ROW_W     = 16;  // columns carried in one row
    localparam int ROW_IDX_W = 4;   // width of the emitted row index
    localparam int VC_W      = 5;   // vertex_count register width
    localparam int ADDR_W    = 3;   // APB byte address width
    localparam int DATA_W    = 32;

    localparam logic [VC_W-1:0] VC_RESET = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLOSE = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;   // store the incoming row
        logic close;  // run one pivot step
        logic emit;   // present one closure row
    } t_dp_cmd;

    typedef struct packed {
        logic load_last;  // the next row completes the matrix
        logic step_last;  // step counter sits on row n-1
    } t_dp_sts;

endpackage

/* design/tce_ctrl.sv */
// ----------------------------------------------------------------------------
// tce_ctrl
// Controller: walks load -> closure -> emit and drives the datapath commands.
// ----------------------------------------------------------------------------
module tce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  tce_pkg::t_dp_sts i_sts,
    output tce_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    tce_pkg::t_state r_state;
    tce_pkg::t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.close = 1'b0;
        o_cmd.emit  = 1'b0;
        unique case (r_state)
            tce_pkg::ST_IDLE: begin
                o_cmd.load = i_start;
                if (i_start && i_sts.load_last) begin
                    n_state = tce_pkg::ST_CLOSE;
                end
            end
            tce_pkg::ST_CLOSE: begin
                o_cmd.close = 1'b1;
                if (i_sts.step_last) begin
                    n_state = tce_pkg::ST_EMIT;
                end
            end
            tce_pkg::ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.step_last) begin
                    n_state = tce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tce_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != tce_pkg::ST_IDLE);

`ifndef SYNTH
    // the final pivot step hands over to the emit phase
    a_close_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tce_pkg::ST_CLOSE && i_sts.step_last) |=> (r_state == tce_pkg::ST_EMIT))
        else $error("closure did not move to emit");

    // a load is never issued while the engine is busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!o_busy && !o_cmd.close && !o_cmd.emit))
        else $error("load issued during closure or emit");
`endif

endmodule

/* design/tce_datapath.sv */
// ----------------------------------------------------------------------------
// tce_datapath
// Row store, load and step counters, one pivot step per cycle over all rows
// in parallel, and the registered result stage.
// ----------------------------------------------------------------------------
module tce_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tce_pkg::t_dp_cmd                  i_cmd,
    input  logic [tce_pkg::VC_W-1:0]          i_vertex_count,
    input  logic [tce_pkg::ROW_W-1:0]         i_row_bits,
    output tce_pkg::t_dp_sts                  o_sts,
    output logic                              o_result_valid,
    output logic [tce_pkg::ROW_IDX_W-1:0]     o_row_index,
    output logic [tce_pkg::ROW_W-1:0]         o_reach_bits,
    output logic                              o_last_row
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int SX_W  = IDX_W + tce_pkg::ROW_IDX_W;

    logic [tce_pkg::ROW_W-1:0] r_rows [MAX_VERTICES];
    logic [CNT_W-1:0]          r_rows_loaded;
    logic [IDX_W-1:0]          r_step;

    logic [CNT_W-1:0]              n_act;
    logic [tce_pkg::ROW_W-1:0]     col_mask;
    logic [tce_pkg::ROW_W-1:0]     pivot_row;
    logic [SX_W-1:0]               step_ext;
    logic [tce_pkg::ROW_IDX_W-1:0] pivot_col;
    logic                          col_ok;

    // active vertex count: zero counts as one, saturate at the store depth
    always_comb begin
        if (i_vertex_count == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(i_vertex_count) > 32'(MAX_VERTICES)) begin
            n_act = CNT_W'(MAX_VERTICES);
        end else begin
            n_act = CNT_W'(i_vertex_count);
        end
    end

    always_comb begin
        for (int j = 0; j < tce_pkg::ROW_W; j++) begin
            col_mask[j] = (32'(n_act) > j);
        end
    end

    assign o_sts.load_last = ((r_rows_loaded + CNT_W'(1)) >= n_act);
    assign o_sts.step_last = ((CNT_W'(r_step) + CNT_W'(1)) == n_act);

    assign step_ext  = SX_W'(r_step);
    assign pivot_col = step_ext[tce_pkg::ROW_IDX_W-1:0];
    // pivots past the last stored column change nothing
    assign col_ok    = (step_ext < SX_W'(tce_pkg::ROW_W));
    assign pivot_row = r_rows[r_step];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rows[r_rows_loaded[IDX_W-1:0]] <= i_row_bits & col_mask;
        end else if (i_cmd.close) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                if (col_ok && r_rows[i][pivot_col]) begin
                    r_rows[i] <= r_rows[i] | pivot_row;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_loaded <= '0;
            r_step        <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rows_loaded <= o_sts.load_last ? '0 : r_rows_loaded + CNT_W'(1);
            end
            if (i_cmd.close || i_cmd.emit) begin
                r_step <= o_sts.step_last ? '0 : r_step + IDX_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_row_index  <= pivot_col;
            o_reach_bits <= pivot_row;
            o_last_row   <= o_sts.step_last;
        end
    end

`ifndef SYNTH
    // the load pointer always stays inside the row store
    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows_loaded < CNT_W'(MAX_VERTICES))
        else $error("load pointer beyond row store");

    // closure and emit run with the load pointer cleared
    a_load_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.close || i_cmd.emit) |-> (r_rows_loaded == '0))
        else $error("row count not cleared after matrix completed");
`endif

endmodule

/* design/transitive_closure_engine_core.sv */
// ----------------------------------------------------------------------------
// transitive_closure_engine_core
// Warshall transitive closure of a directed graph held as a bit matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Rows of the adjacency matrix enter on i_row_bits, one item per cycle,
//   accepted when start is high and busy is low. Row bits at or beyond the
//   active vertex count n are dropped.
//   When the n-th row is accepted, busy rises and the closure runs one pivot
//   per cycle over all rows in parallel, then the closed rows leave one per
//   cycle on o_row_index / o_reach_bits / o_last_row, each marked by
//   o_result_valid for one cycle; o_last_row flags row n-1. Every result
//   row is registered in the result stage before it shows on the outputs.
//   busy falls in the cycle that shows the last row, so the next matrix can
//   load at once. Results cannot be held off: the sink takes every strobe.
//   vertex_count (APB, byte address 0, reset 16) sets n; zero acts as one and
//   values above MAX_VERTICES saturate. Reset clears the row count and returns
//   to the load phase; the row store keeps no reset value.
// ----------------------------------------------------------------------------
module transitive_closure_engine_core #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tce_pkg::ROW_W-1:0]           i_row_bits,
    output logic                                o_result_valid,
    output logic [tce_pkg::ROW_IDX_W-1:0]       o_row_index,
    output logic [tce_pkg::ROW_W-1:0]           o_reach_bits,
    output logic                                o_last_row,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tce_pkg::ADDR_W-1:0]          paddr,
    input  logic [tce_pkg::DATA_W-1:0]          pwdata,
    output logic [tce_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    logic [tce_pkg::VC_W-1:0] r_vertex_count;
    logic                     reg_sel;
    tce_pkg::t_dp_cmd         dp_cmd;
    tce_pkg::t_dp_sts         dp_sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == tce_pkg::REG_VERTEX_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= tce_pkg::VC_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_vertex_count <= pwdata[tce_pkg::VC_W-1:0];
        end
    end

    assign prdata = reg_sel ? tce_pkg::DATA_W'(r_vertex_count) : '0;

    tce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy)
    );

    tce_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_vertex_count (r_vertex_count),
        .i_row_bits     (i_row_bits),
        .o_sts          (dp_sts),
        .o_result_valid (o_result_valid),
        .o_row_index    (o_row_index),
        .o_reach_bits   (o_reach_bits),
        .o_last_row     (o_last_row)
    );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: transitive closure engine testbench
// Loads adjacency matrices row by row and sets the vertex count over APB. A
// Warshall predictor in the scoreboard computes the closed rows that every
// finished matrix should produce. Each strobed result row is compared with
// the oldest predicted row. Directed matrices come first, then random ones.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_V       = 16;
    localparam int STALL_LIMIT = 500;

    typedef struct packed {
        logic [tce_pkg::ROW_IDX_W-1:0] row_index;
        logic [tce_pkg::ROW_W-1:0]     reach_bits;
        logic                          last_row;
    } t_closure_row;

    class t_closure_scoreboard;
        logic [tce_pkg::ROW_W-1:0] adj_rows [MAX_V];
        int unsigned               rows_seen;
        logic [tce_pkg::VC_W-1:0]  vcount_reg;
        t_closure_row              expected_rows [$];
        int unsigned               fail_count;

        function new();
            foreach (adj_rows[i]) adj_rows[i] = '0;
            rows_seen  = 0;
            vcount_reg = tce_pkg::VC_RESET;
            fail_count = 0;
        endfunction

        function int unsigned active_n();
            if (vcount_reg == 0) return 1;
            if (vcount_reg > MAX_V) return MAX_V;
            return vcount_reg;
        endfunction

        function void set_vertex_count(logic [tce_pkg::VC_W-1:0] value);
            vcount_reg = value;
        endfunction

        // Store one accepted row; once the matrix is complete, close it and
        // queue the rows it must emit.
        function void note_row(logic [tce_pkg::ROW_W-1:0] bits);
            int unsigned               n;
            logic [tce_pkg::ROW_W-1:0] col_mask;
            logic [tce_pkg::ROW_W-1:0] pivot_row;
            t_closure_row              row_out;
            n = active_n();
            col_mask = (n >= tce_pkg::ROW_W) ? {tce_pkg::ROW_W{1'b1}}
                                             : tce_pkg::ROW_W'((32'd1 << n) - 1);
            if (rows_seen < MAX_V)
                adj_rows[rows_seen] = bits & col_mask;
            rows_seen++;
            if (rows_seen < n) return;
            for (int k = 0; k < n; k++) begin
                pivot_row = adj_rows[k];
                for (int i = 0; i < n; i++) begin
                    if (adj_rows[i][k])
                        adj_rows[i] = adj_rows[i] | pivot_row;
                end
            end
            for (int r = 0; r < n; r++) begin
                row_out.row_index  = tce_pkg::ROW_IDX_W'(r);
                row_out.reach_bits = adj_rows[r];
                row_out.last_row   = (r + 1 == n);
                expected_rows.push_back(row_out);
            end
            rows_seen = 0;
        endfunction

        function void check_row(logic [tce_pkg::ROW_IDX_W-1:0] idx,
                                logic [tce_pkg::ROW_W-1:0] bits, logic last);
            t_closure_row want;
            if (expected_rows.size() == 0) begin
                $error("unexpected closure row: row_index %0d reach_bits %h", idx, bits);
                fail_count++;
                return;
            end
            want = expected_rows.pop_front();
            if (idx !== want.row_index) begin
                $error("row_index: expected %0d, got %0d", want.row_index, idx);
                fail_count++;
            end
            if (bits !== want.reach_bits) begin
                $error("reach_bits: expected %h, got %h", want.reach_bits, bits);
                fail_count++;
            end
            if (last !== want.last_row) begin
                $error("last_row: expected %0b, got %0b", want.last_row, last);
                fail_count++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [tce_pkg::ROW_W-1:0]      i_row_bits;
    logic                           o_result_valid;
    logic [tce_pkg::ROW_IDX_W-1:0]  o_row_index;
    logic [tce_pkg::ROW_W-1:0]      o_reach_bits;
    logic                           o_last_row;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [tce_pkg::ADDR_W-1:0]     paddr;
    logic [tce_pkg::DATA_W-1:0]     pwdata;
    logic [tce_pkg::DATA_W-1:0]     prdata;
    logic                           pready;

    t_closure_scoreboard   sb;
    int unsigned           idle_pct;
    int unsigned           rows_sent;

    transitive_closure_engine_core #(
        .MAX_VERTICES (MAX_V)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_row_bits     (i_row_bits),
        .o_result_valid (o_result_valid),
        .o_row_index    (o_row_index),
        .o_reach_bits   (o_reach_bits),
        .o_last_row     (o_last_row),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic push_row(input logic [tce_pkg::ROW_W-1:0] bits);
        if ($urandom_range(0, 99) < idle_pct) begin
            start      <= 1'b0;
            i_row_bits <= tce_pkg::ROW_W'($urandom);
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_row_bits <= bits;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_row(bits);
        rows_sent++;
    endtask

    // Drop start, wait for every predicted row, then let the block settle.
    task automatic settle_block();
        start <= 1'b0;
        while (sb.expected_rows.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [tce_pkg::VC_W-1:0] value);
        logic [tce_pkg::DATA_W-1:0] word;
        word = tce_pkg::DATA_W'($urandom);
        word[tce_pkg::VC_W-1:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {tce_pkg::REG_VERTEX_COUNT, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_vertex_count(value);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_row(o_row_index, o_reach_bits, o_last_row);
    end

    initial begin
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_result_valid || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned               pick;
        int unsigned               style;
        int unsigned               n;
        logic [tce_pkg::VC_W-1:0]  vcount;
        logic [tce_pkg::ROW_W-1:0] row;
        sb         = new();
        idle_pct   = 38;
        rows_sent  = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_row_bits <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Chain at the reset vertex count: row i reaches every j above i.
        for (int i = 0; i < MAX_V; i++)
            push_row(i == MAX_V - 1 ? 16'h8000 : tce_pkg::ROW_W'(1) << (i + 1));
        settle_block();
        write_vertex_count(5'd1);
        push_row(16'hFFFF);
        settle_block();
        // zero count acts as one vertex
        write_vertex_count(5'd0);
        push_row(16'h0001);
        settle_block();
        // Saturated count, then lower it mid-load: the next row completes.
        write_vertex_count(5'd31);
        for (int i = 0; i < 3; i++) push_row(16'hFFFF);
        settle_block();
        write_vertex_count(5'd2);
        push_row(16'hAAAA);
        settle_block();

        while (rows_sent < 460) begin
            idle_pct = (rows_sent >= 220 && rows_sent < 320) ? 0 : 38;
            pick = $urandom_range(0, 99);
            if (pick < 8)       vcount = 5'd0;
            else if (pick < 16) vcount = 5'd1;
            else if (pick < 30) vcount = 5'd16;
            else if (pick < 40) vcount = tce_pkg::VC_W'($urandom_range(17, 31));
            else                vcount = tce_pkg::VC_W'($urandom_range(2, 15));
            write_vertex_count(vcount);
            repeat ($urandom_range(1, 3)) begin
                style = $urandom_range(0, 4);
                n = sb.active_n();
                // Now and then change the count with the matrix half loaded.
                if (n >= 2 && $urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(1, n - 1))
                        push_row(tce_pkg::ROW_W'($urandom));
                    settle_block();
                    write_vertex_count(tce_pkg::VC_W'($urandom_range(0, 31)));
                end
                do begin
                    case (style)
                        0:       row = tce_pkg::ROW_W'($urandom);
                        1:       row = tce_pkg::ROW_W'(1)
                                       << $urandom_range(0, tce_pkg::ROW_W - 1);
                        2:       row = tce_pkg::ROW_W'($urandom & $urandom & $urandom);
                        3:       row = ($urandom_range(0, 3) == 0) ? '0 : '1;
                        default: row = tce_pkg::ROW_W'($urandom & $urandom);
                    endcase
                    push_row(row);
                end while (sb.rows_seen != 0);
            end
            settle_block();
        end

        settle_block();
        repeat (16) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.expected_rows.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* transitive_closure_engine_core.f */
design/tce_pkg.sv
design/tce_ctrl.sv
design/tce_datapath.sv
design/transitive_closure_engine_core.sv
sim/tb.sv
